>>> hw/rtl/md5_pkg.sv
package md5_pkg;

  localparam logic [31:0] InitA = 32'h67452301;
  localparam logic [31:0] InitB = 32'hefcdab89;
  localparam logic [31:0] InitC = 32'h98badcfe;
  localparam logic [31:0] InitD = 32'h10325476;
  localparam logic [7:0]  PadMark = 8'h80;
  localparam logic [5:0]  PadStop = 6'd56;

  // compression unit status
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } md5_core_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD_MARK,
    ST_PAD_FILL,
    ST_LEN,
    ST_WAIT,
    ST_OUT
  } md5_state_t;

  function automatic logic [31:0] md5_sine(input logic [5:0] i);
    logic [31:0] r;
    begin
      case (i)
        6'd0:  r = 32'hd76aa478; 6'd1:  r = 32'he8c7b756; 6'd2:  r = 32'h242070db;
        6'd3:  r = 32'hc1bdceee; 6'd4:  r = 32'hf57c0faf; 6'd5:  r = 32'h4787c62a;
        6'd6:  r = 32'ha8304613; 6'd7:  r = 32'hfd469501; 6'd8:  r = 32'h698098d8;
        6'd9:  r = 32'h8b44f7af; 6'd10: r = 32'hffff5bb1; 6'd11: r = 32'h895cd7be;
        6'd12: r = 32'h6b901122; 6'd13: r = 32'hfd987193; 6'd14: r = 32'ha679438e;
        6'd15: r = 32'h49b40821; 6'd16: r = 32'hf61e2562; 6'd17: r = 32'hc040b340;
        6'd18: r = 32'h265e5a51; 6'd19: r = 32'he9b6c7aa; 6'd20: r = 32'hd62f105d;
        6'd21: r = 32'h02441453; 6'd22: r = 32'hd8a1e681; 6'd23: r = 32'he7d3fbc8;
        6'd24: r = 32'h21e1cde6; 6'd25: r = 32'hc33707d6; 6'd26: r = 32'hf4d50d87;
        6'd27: r = 32'h455a14ed; 6'd28: r = 32'ha9e3e905; 6'd29: r = 32'hfcefa3f8;
        6'd30: r = 32'h676f02d9; 6'd31: r = 32'h8d2a4c8a; 6'd32: r = 32'hfffa3942;
        6'd33: r = 32'h8771f681; 6'd34: r = 32'h6d9d6122; 6'd35: r = 32'hfde5380c;
        6'd36: r = 32'ha4beea44; 6'd37: r = 32'h4bdecfa9; 6'd38: r = 32'hf6bb4b60;
        6'd39: r = 32'hbebfbc70; 6'd40: r = 32'h289b7ec6; 6'd41: r = 32'heaa127fa;
        6'd42: r = 32'hd4ef3085; 6'd43: r = 32'h04881d05; 6'd44: r = 32'hd9d4d039;
        6'd45: r = 32'he6db99e5; 6'd46: r = 32'h1fa27cf8; 6'd47: r = 32'hc4ac5665;
        6'd48: r = 32'hf4292244; 6'd49: r = 32'h432aff97; 6'd50: r = 32'hab9423a7;
        6'd51: r = 32'hfc93a039; 6'd52: r = 32'h655b59c3; 6'd53: r = 32'h8f0ccc92;
        6'd54: r = 32'hffeff47d; 6'd55: r = 32'h85845dd1; 6'd56: r = 32'h6fa87e4f;
        6'd57: r = 32'hfe2ce6e0; 6'd58: r = 32'ha3014314; 6'd59: r = 32'h4e0811a1;
        6'd60: r = 32'hf7537e82; 6'd61: r = 32'hbd3af235; 6'd62: r = 32'h2ad7d2bb;
        default: r = 32'heb86d391;
      endcase
      return r;
    end
  endfunction

  function automatic logic [4:0] md5_shift(input logic [5:0] i);
    logic [4:0] r;
    begin
      case ({i[5:4], i[1:0]})
        4'h0: r = 5'd7;  4'h1: r = 5'd12; 4'h2: r = 5'd17; 4'h3: r = 5'd22;
        4'h4: r = 5'd5;  4'h5: r = 5'd9;  4'h6: r = 5'd14; 4'h7: r = 5'd20;
        4'h8: r = 5'd4;  4'h9: r = 5'd11; 4'ha: r = 5'd16; 4'hb: r = 5'd23;
        4'hc: r = 5'd6;  4'hd: r = 5'd10; 4'he: r = 5'd15; default: r = 5'd21;
      endcase
      return r;
    end
  endfunction

  // message word used by a round
  function automatic logic [3:0] md5_widx(input logic [5:0] i);
    logic [3:0] r;
    begin
      unique case (i[5:4])
        2'd0: r = i[3:0];
        2'd1: r = 4'((i[3:0] * 4'd5) + 4'd1);
        2'd2: r = 4'((i[3:0] * 4'd3) + 4'd5);
        default: r = 4'(i[3:0] * 4'd7);
      endcase
      return r;
    end
  endfunction

endpackage

>>> hw/rtl/md5_core.sv
module md5_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic                   wr_en,
  input  logic [5:0]             wr_addr,
  input  logic [7:0]             wr_byte,
  input  logic                   clear,
  output md5_pkg::md5_core_ctl_t ctl,
  output logic [31:0]            chain_a,
  output logic [31:0]            chain_b,
  output logic [31:0]            chain_c,
  output logic [31:0]            chain_d
);
  import md5_pkg::*;

  // block buffer as sixteen 32-bit words, byte-writable
  logic [7:0]  mem0 [16];
  logic [7:0]  mem1 [16];
  logic [7:0]  mem2 [16];
  logic [7:0]  mem3 [16];
  logic [31:0] rd_word;
  logic [3:0]  rd_addr;

  logic        busy;
  logic        rnd_valid;
  logic [5:0]  round;
  logic [5:0]  rnd_idx;
  logic        done;
  logic [31:0] a, b, c, d;
  logic [31:0] f, t, rot;
  logic [4:0]  sh;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      unique case (wr_addr[1:0])
        2'd0: mem0[wr_addr[5:2]] <= wr_byte;
        2'd1: mem1[wr_addr[5:2]] <= wr_byte;
        2'd2: mem2[wr_addr[5:2]] <= wr_byte;
        default: mem3[wr_addr[5:2]] <= wr_byte;
      endcase
    end
    rd_word <= {mem3[rd_addr], mem2[rd_addr], mem1[rd_addr], mem0[rd_addr]};
  end

  // word for the next round is read into a register during the current round
  assign rd_addr = md5_widx(round);

  always_comb begin
    unique case (rnd_idx[5:4])
      2'd0: f = (b & c) | (~b & d);
      2'd1: f = (d & b) | (~d & c);
      2'd2: f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    t   = f + a + md5_sine(rnd_idx) + rd_word;
    sh  = md5_shift(rnd_idx);
    rot = (t << sh) | (t >> (6'd32 - {1'b0, sh}));
  end

  // round sequencer: one round per cycle while busy, starting right after start
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rnd_valid <= 1'b0;
      round <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        round <= 6'd1;
        rnd_idx <= 6'd0;
        rnd_valid <= 1'b1;
      end else if (busy) begin
        if (rnd_idx == 6'd63) begin
          busy <= 1'b0;
          rnd_valid <= 1'b0;
          done <= 1'b1;
        end else begin
          rnd_idx <= rnd_idx + 6'd1;
          round <= round + 6'd1;
        end
      end
    end
  end

  // working registers and chaining words
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      chain_a <= InitA;
      chain_b <= InitB;
      chain_c <= InitC;
      chain_d <= InitD;
    end else if (done) begin
      chain_a <= chain_a + a;
      chain_b <= chain_b + b;
      chain_c <= chain_c + c;
      chain_d <= chain_d + d;
    end
    if (start && !busy) begin
      a <= chain_a;
      b <= chain_b;
      c <= chain_c;
      d <= chain_d;
    end else if (busy && rnd_valid) begin
      a <= d;
      d <= c;
      c <= b;
      b <= b + rot;
    end
  end

  assign ctl.start = start;
  assign ctl.busy  = busy | done;
  assign ctl.done  = done;
endmodule

>>> hw/rtl/md5_stream_hasher.sv
// an item that fills a block stalls input until its compression is done; other
// message bytes do not stall input; the final item pads through the memory one
// byte a cycle while no compression runs, and may compress twice before the digest
// is valid; one round per cycle in the shared compression unit sets the rate
// rst is synchronous; it restores the initial chaining words and empty counts
module md5_stream_hasher (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // data_byte
  input  logic         s_tuser,   // has_byte
  input  logic         s_tlast,   // last
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata    // hash_a, hash_b, hash_c, hash_d
);
  import md5_pkg::*;

  md5_state_t    state, state_next;
  md5_core_ctl_t ctl;
  logic [5:0]    fill_index;
  logic [60:0]   message_bytes;
  logic [63:0]   bits;
  logic [2:0]    len_idx;
  logic          pend;
  logic          accept;
  logic          wr_en, start, clear;
  logic [7:0]    wr_byte;
  logic [31:0]   ha, hb, hc, hd;

  assign bits   = {message_bytes, 3'b000};
  assign accept = s_tvalid && s_tready;

  md5_core u_core (
    .clk(clk), .rst(rst), .start(start), .wr_en(wr_en), .wr_addr(fill_index),
    .wr_byte(wr_byte), .clear(clear), .ctl(ctl),
    .chain_a(ha), .chain_b(hb), .chain_c(hc), .chain_d(hd)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (accept && s_tlast) state_next = ST_PAD_MARK;
      ST_PAD_MARK: if (!pend && !ctl.busy) state_next = ST_PAD_FILL;
      ST_PAD_FILL: if (!pend && !ctl.busy && fill_index == PadStop) state_next = ST_LEN;
      ST_LEN:      if (!pend && !ctl.busy && len_idx == 3'd7) state_next = ST_WAIT;
      ST_WAIT:     if (!pend && !ctl.busy) state_next = ST_OUT;
      ST_OUT:      if (m_tready) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // outputs: one buffer write per cycle while no compression is pending or busy, start when a block closes
  always_comb begin
    wr_en = 1'b0;
    wr_byte = s_tdata;
    clear = 1'b0;
    s_tready = (state == ST_IDLE) && !pend && !ctl.busy;
    m_tvalid = (state == ST_OUT);
    unique case (state)
      ST_IDLE:     wr_en = accept && s_tuser;
      ST_PAD_MARK: begin
        wr_en = !pend && !ctl.busy;
        wr_byte = PadMark;
      end
      ST_PAD_FILL: begin
        wr_en = !pend && !ctl.busy && fill_index != PadStop;
        wr_byte = 8'h00;
      end
      ST_LEN:      begin
        wr_en = !pend && !ctl.busy;
        wr_byte = bits[{len_idx, 3'b000} +: 8];
      end
      ST_WAIT:     ;
      ST_OUT:      clear = m_tready;
      default:     ;
    endcase
    start = pend;
  end

  // fill position, length and pending compression
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fill_index <= '0;
      message_bytes <= '0;
      len_idx <= '0;
      pend <= 1'b0;
    end else begin
      state <= state_next;
      pend <= 1'b0;
      if (wr_en) begin
        fill_index <= fill_index + 6'd1;
        pend <= (fill_index == 6'd63);
      end
      if (accept && s_tuser) message_bytes <= message_bytes + 61'd1;
      if (state == ST_LEN && wr_en) len_idx <= len_idx + 3'd1;
      if (clear) begin
        message_bytes <= '0;
        len_idx <= '0;
      end
    end
  end

  assign m_tdata = {hd, hc, hb, ha};
endmodule

>>> verif/tb_md5_stream_hasher.sv
module tb_md5_stream_hasher;
  timeunit 1ns;
  timeprecision 1ps;

  import md5_pkg::*;

  typedef struct {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } md5_word_t;

  typedef struct {
    logic [31:0] a, b, c, d;
  } md5_digest_t;

  localparam int WatchdogLimit = 4000;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [7:0]   s_tdata;
  logic         s_tuser;
  logic         s_tlast;
  logic         m_tvalid;
  logic         m_tready;
  logic [127:0] m_tdata;

  md5_stream_hasher uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  md5_word_t   pending_words[$];
  md5_digest_t digest_fifo[$];
  int          error_count;
  int          idle_cycles;
  bit          hold_off;

  // handshakes seen at the last rising edge
  bit s_tready_seen, m_tvalid_seen;

  // hasher state mirror
  logic [31:0] hash_state[4];
  logic [7:0]  block_bytes[64];
  logic [5:0]  fill_count;
  logic [60:0] msg_len;

  localparam logic [31:0] SineK[64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf, 32'h4787c62a,
    32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821, 32'hf61e2562, 32'hc040b340,
    32'h265e5a51, 32'he9b6c7aa, 32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
    32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70, 32'h289b7ec6, 32'heaa127fa,
    32'hd4ef3085, 32'h04881d05, 32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92,
    32'hffeff47d, 32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};

  localparam int RotK[16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

  function automatic void clear_hash_state();
    hash_state[0] = InitA;
    hash_state[1] = InitB;
    hash_state[2] = InitC;
    hash_state[3] = InitD;
    fill_count = '0;
    msg_len = '0;
    foreach (block_bytes[i]) block_bytes[i] = '0;
  endfunction

  // 64-round block compression into the chaining words
  function automatic void compress_block();
    logic [31:0] w[16];
    logic [31:0] a, b, c, d, f, t, rot;
    int g;
    for (int i = 0; i < 16; i++)
      w[i] = {block_bytes[4*i+3], block_bytes[4*i+2], block_bytes[4*i+1], block_bytes[4*i]};
    a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
    for (int i = 0; i < 64; i++) begin
      if (i < 16) begin
        f = (b & c) | (~b & d); g = i;
      end else if (i < 32) begin
        f = (d & b) | (~d & c); g = (5 * i + 1) % 16;
      end else if (i < 48) begin
        f = b ^ c ^ d; g = (3 * i + 5) % 16;
      end else begin
        f = c ^ (b | ~d); g = (7 * i) % 16;
      end
      t = f + a + SineK[i] + w[g];
      rot = (t << RotK[(i / 16) * 4 + i % 4]) | (t >> (32 - RotK[(i / 16) * 4 + i % 4]));
      a = d; d = c; c = b; b = b + rot;
    end
    hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
  endfunction

  function automatic void absorb_byte(logic [7:0] v);
    block_bytes[fill_count] = v;
    fill_count = fill_count + 6'd1;
    if (fill_count == 6'd0) compress_block();
  endfunction

  // one accepted word; queues a digest on end of message
  function automatic void hash_word(md5_word_t wd);
    logic [63:0] bit_len;
    md5_digest_t dg;
    if (wd.has_byte) begin
      absorb_byte(wd.data_byte);
      msg_len = msg_len + 61'd1;
    end
    if (!wd.last) return;
    bit_len = {msg_len, 3'b000};
    absorb_byte(PadMark);
    while (fill_count != PadStop) absorb_byte(8'h00);
    for (int k = 0; k < 8; k++) absorb_byte(bit_len[8*k +: 8]);
    dg.a = hash_state[0]; dg.b = hash_state[1]; dg.c = hash_state[2]; dg.d = hash_state[3];
    digest_fifo.push_back(dg);
    clear_hash_state();
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %08h expected %08h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic void add_word(logic [7:0] v, bit hb, bit lst);
    md5_word_t wd;
    wd.data_byte = v; wd.has_byte = hb; wd.last = lst;
    pending_words.push_back(wd);
  endfunction

  function automatic void add_message(int len, bit noise, bit byte_on_last);
    int n;
    n = byte_on_last && len > 0 ? len - 1 : len;
    for (int i = 0; i < n; i++) begin
      if (noise && $urandom_range(0, 7) == 0) add_word(8'($urandom), 1'b0, 1'b0);
      add_word(8'($urandom), 1'b1, 1'b0);
    end
    if (byte_on_last && len > 0) add_word(8'($urandom), 1'b1, 1'b1);
    else add_word(8'($urandom), 1'b0, 1'b1);
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // sender
  int send_gap;
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap = $urandom_range(0, 7);
    end else if (!s_tvalid || s_tready_seen) begin
      if (send_gap > 0 || hold_off || pending_words.size() == 0) begin
        if (send_gap > 0) send_gap--;
        s_tvalid <= 1'b0;
      end else begin
        s_tvalid <= 1'b1;
        s_tdata  <= pending_words[0].data_byte;
        s_tuser  <= pending_words[0].has_byte;
        s_tlast  <= pending_words[0].last;
        void'(pending_words.pop_front());
        send_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 7);
      end
    end
  end

  // receiver stalls
  int recv_gap;
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      recv_gap = 0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if (m_tvalid_seen) recv_gap = $urandom_range(0, 1) ? 0 : $urandom_range(0, 7);
    end
  end

  // monitor: check digests and count idle cycles
  always @(posedge clk) begin
    md5_digest_t want;
    md5_word_t   wd;
    s_tready_seen <= !rst && s_tvalid && s_tready;
    m_tvalid_seen <= !rst && m_tvalid && m_tready;
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (s_tvalid && s_tready) begin
        wd.data_byte = s_tdata; wd.has_byte = s_tuser; wd.last = s_tlast;
        hash_word(wd);
      end
      if (m_tvalid && m_tready) begin
        if (digest_fifo.size() == 0) begin
          $display("unexpected digest %032h at %0t", m_tdata, $realtime);
          error_count++;
        end else begin
          want = digest_fifo.pop_front();
          if (m_tdata[31:0] !== want.a) report_mismatch("hash_a", m_tdata[31:0], want.a);
          if (m_tdata[63:32] !== want.b) report_mismatch("hash_b", m_tdata[63:32], want.b);
          if (m_tdata[95:64] !== want.c) report_mismatch("hash_c", m_tdata[95:64], want.c);
          if (m_tdata[127:96] !== want.d) report_mismatch("hash_d", m_tdata[127:96], want.d);
        end
      end
    end
  end

  // reset, stimulus, watchdog and end of run
  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0; s_tdata = '0; s_tuser = 1'b0; s_tlast = 1'b0; m_tready = 1'b0;
    error_count = 0; idle_cycles = 0; hold_off = 1'b0;
    clear_hash_state();

    // directed: empty message, byte on last, idles, boundary lengths
    add_word(8'h00, 1'b0, 1'b1);
    add_word(8'hff, 1'b0, 1'b0);
    add_word(8'h61, 1'b1, 1'b1);
    add_word(8'h00, 1'b1, 1'b0);
    add_word(8'hff, 1'b1, 1'b0);
    add_word(8'h55, 1'b0, 1'b0);
    add_word(8'haa, 1'b1, 1'b0);
    add_word(8'h00, 1'b0, 1'b1);
    add_message(55, 1'b0, 1'b1);
    add_message(56, 1'b0, 1'b0);
    add_message(64, 1'b0, 1'b1);
    add_message(120, 1'b0, 1'b0);
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // pause until every digest is in
    while ((pending_words.size() != 0 || s_tvalid) && idle_cycles < WatchdogLimit)
      @(posedge clk);
    hold_off = 1'b1;
    while (digest_fifo.size() != 0 && idle_cycles < WatchdogLimit) @(posedge clk);
    hold_off = 1'b0;

    // random messages, mostly short, some across block edges
    for (int i = 0; i < 48; i++)
      add_message($urandom_range(0, 3) == 0 ? $urandom_range(50, 70) : $urandom_range(0, 40),
                  1'b1, $urandom_range(0, 1));

    while ((pending_words.size() != 0 || s_tvalid || digest_fifo.size() != 0)
           && idle_cycles < WatchdogLimit) @(posedge clk);
    if (idle_cycles >= WatchdogLimit) begin
      $display("simulation failed");
      $finish;
    end else begin
      repeat (250) @(posedge clk);
      if (error_count == 0 && digest_fifo.size() == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
    end
  end

endmodule
